// File: hdl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// NOR flash array model package
// Shared sizes, codes, the queued request type and the protection helper.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int FLASH_BYTES  = 262144;
    localparam int SECTOR_BYTES = 65536;
    localparam int PAGE_BYTES   = 256;
    localparam int READ_BURST   = 64;
    localparam int NUM_SECTORS  = FLASH_BYTES / SECTOR_BYTES;

    localparam int ADDR_W = 18;
    localparam int LEN_W  = 19;
    localparam int SEC_W  = $clog2(NUM_SECTORS);
    localparam int SOFF_W = $clog2(SECTOR_BYTES);
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int BCNT_W = PAGE_W + 1;
    localparam int CNT_W  = 32;
    localparam int PROT_W = 12;

    localparam logic [7:0] ERASED = 8'hFF;

    localparam int PROT_WRITE = 0;
    localparam int PROT_ERASE = 1;
    localparam int PROT_READ  = 2;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_ERASE = 3'd2,
        OP_CMP   = 3'd3,
        OP_BLANK = 3'd4,
        OP_STATS = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ADDR  = 3'd1,
        ST_WFAIL = 3'd2,
        ST_PROT  = 3'd3,
        ST_CMP   = 3'd4,
        ST_LEN   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_READ  = 3'd0,
        K_BEAT  = 3'd1,
        K_ERASE = 3'd2,
        K_BLANK = 3'd3,
        K_STATS = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               is_cmp;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic               range_bad;
        logic               read_long;
        logic               page_long;
        logic               erase_bad;
        logic [2:0]         er_first;
        logic [2:0]         er_count;
        logic [7:0]         data_byte;
        logic               data_last;
    } item_t;

    function automatic logic [2:0] prot_bits(input logic [PROT_W-1:0] cfg,
                                             input logic [SEC_W-1:0] sec);
        prot_bits = cfg[3*sec +: 3];
    endfunction

endpackage

// File: hdl/nfa_cmd_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one flash request.
// ----------------------------------------------------------------------------
interface nfa_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [17:0] address;
    logic [18:0] length;
    logic [2:0]  sector_index;
    logic [2:0]  sector_count;
    logic [7:0]  data_byte;
    logic        data_last;

    modport source (output valid, op, address, length, sector_index, sector_count,
                    data_byte, data_last, input ready);
    modport sink (input valid, op, address, length, sector_index, sector_count,
                  data_byte, data_last, output ready);
endinterface

// File: hdl/nfa_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result.
// ----------------------------------------------------------------------------
interface nfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [31:0] total_erases;
    logic [31:0] max_erase_count;
    logic        last;

    modport source (output valid, status, read_byte, total_erases, max_erase_count,
                    last, input ready);
    modport sink (input valid, status, read_byte, total_erases, max_erase_count,
                  last, output ready);
endinterface

// File: hdl/nor_flash_array_model_core.sv
// ----------------------------------------------------------------------------
// NOR flash array model
// Front end, request queue and execution engine around a byte flash array.
// ----------------------------------------------------------------------------
// Channel   Direction   Contents
// cmd       in          one request or one write/compare data beat
// rsp       out         one result; last marks the final one of a request
// cfg       in          sector protection register, write only
//
// After reset a clearing pass fills all 262144 bytes of the array with 0xFF;
// no request is taken during that pass. A read fetches and returns one byte
// at a time; a write checks every byte against the page buffer and then
// programs it; compare and blank checks read each byte once; an erase writes
// every byte of the erased sectors. All are limited by the single array port.
// The result register lets the front end keep queueing while a result waits.
// ----------------------------------------------------------------------------
module nor_flash_array_model_core
(
    input  logic        clk,
    input  logic        rst_n,
    nfa_cmd_if.sink     cmd,
    nfa_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data
);

    logic [nfa_pkg::PROT_W-1:0] prot_reg;
    logic                       push;
    logic                       pop;
    logic                       q_valid;
    logic                       q_full;
    logic                       clearing;
    nfa_pkg::item_t             push_item;
    nfa_pkg::item_t             q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_reg <= '0;
        end
        else if (cfg_we)
        begin
            prot_reg <= cfg_data;
        end
    end

    nfa_front u_front
    (
        .cmd       (cmd),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item)
    );

    nfa_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_item    (q_item)
    );

    nfa_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .prot     (prot_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

// File: hdl/nfa_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, drops unknown operations and precomputes range checks.
// ----------------------------------------------------------------------------
module nfa_front
(
    nfa_cmd_if.sink        cmd,
    input  logic           q_full,
    input  logic           clearing,
    output logic           push,
    output nfa_pkg::item_t push_item
);

    logic [nfa_pkg::LEN_W:0] end_sum;
    logic [3:0]              er_sum;
    logic                    known;

    assign end_sum = {2'b00, cmd.address} + {1'b0, cmd.length};
    assign er_sum  = {1'b0, cmd.sector_index} + {1'b0, cmd.sector_count};

    always_comb
    begin
        known = 1'b1;
        push_item.kind = nfa_pkg::K_STATS;
        unique case (cmd.op)
            nfa_pkg::OP_READ:                    push_item.kind = nfa_pkg::K_READ;
            nfa_pkg::OP_WRITE, nfa_pkg::OP_CMP:  push_item.kind = nfa_pkg::K_BEAT;
            nfa_pkg::OP_ERASE:                   push_item.kind = nfa_pkg::K_ERASE;
            nfa_pkg::OP_BLANK:                   push_item.kind = nfa_pkg::K_BLANK;
            nfa_pkg::OP_STATS:                   push_item.kind = nfa_pkg::K_STATS;
            default:                             known = 1'b0;
        endcase
        push_item.is_cmp    = (cmd.op == nfa_pkg::OP_CMP);
        push_item.addr      = cmd.address;
        push_item.len       = cmd.length;
        push_item.range_bad = (cmd.length == '0) ||
                              (end_sum > (nfa_pkg::LEN_W+1)'(nfa_pkg::FLASH_BYTES));
        push_item.read_long = (cmd.length > nfa_pkg::LEN_W'(nfa_pkg::READ_BURST));
        push_item.page_long = (cmd.length > nfa_pkg::LEN_W'(nfa_pkg::PAGE_BYTES));
        push_item.erase_bad = (cmd.sector_index >= 3'(nfa_pkg::NUM_SECTORS)) ||
                              (er_sum > 4'(nfa_pkg::NUM_SECTORS));
        push_item.er_first  = cmd.sector_index;
        push_item.er_count  = cmd.sector_count;
        push_item.data_byte = cmd.data_byte;
        push_item.data_last = cmd.data_last;
    end

    assign cmd.ready = !q_full && !clearing;
    assign push      = cmd.valid && cmd.ready && known;

endmodule

// File: hdl/nfa_fifo.sv
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module nfa_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nfa_pkg::item_t push_item,
    input  logic           pop,
    output logic           q_valid,
    output logic           q_full,
    output nfa_pkg::item_t q_item
);

    nfa_pkg::item_t entry_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     count_reg, count_next;

    assign q_valid = (count_reg != 2'd0);
    assign q_full  = (count_reg == 2'd2);
    assign q_item  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/nfa_back.sv
// ----------------------------------------------------------------------------
// Execution engine
// Holds the flash array and page buffer and carries out queued requests.
// ----------------------------------------------------------------------------
module nfa_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [nfa_pkg::PROT_W-1:0]   prot,
    input  logic                         q_valid,
    input  nfa_pkg::item_t               q_item,
    output logic                         pop,
    output logic                         clearing,
    nfa_rsp_if.source                    rsp
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_RD_ISSUE = 11'b00000000100,
        S_RD_EMIT  = 11'b00000001000,
        S_CHK_ISS  = 11'b00000010000,
        S_CHK_EVAL = 11'b00000100000,
        S_WR_ISS   = 11'b00001000000,
        S_WR_EXEC  = 11'b00010000000,
        S_ERASE    = 11'b00100000000,
        S_STATS    = 11'b01000000000,
        S_EMIT     = 11'b10000000000
    } state_t;

    typedef enum logic [1:0] {
        M_WRITE = 2'd0,
        M_CMP   = 2'd1,
        M_BLANK = 2'd2
    } mode_t;

    localparam int AW = nfa_pkg::ADDR_W;
    localparam int LW = nfa_pkg::LEN_W;
    localparam int CW = nfa_pkg::CNT_W;

    logic [7:0] flash_mem [nfa_pkg::FLASH_BYTES];
    logic [7:0] page_mem  [nfa_pkg::PAGE_BYTES];

    state_t                      state_reg, state_next;
    mode_t                       mode_reg, mode_next;
    nfa_pkg::item_t              cur_reg, cur_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [LW-1:0]               rem_reg, rem_next;
    logic [nfa_pkg::PAGE_W-1:0]  bidx_reg, bidx_next;
    logic [nfa_pkg::BCNT_W-1:0]  bcount_reg, bcount_next;
    logic [nfa_pkg::SEC_W-1:0]   sidx_reg, sidx_next;
    logic [CW-1:0]               tot_reg, tot_next;
    logic [CW-1:0]               mx_reg, mx_next;
    logic [2:0]                  res_status_reg, res_status_next;
    logic                        res_stats_reg, res_stats_next;
    logic [CW-1:0]               cnt_reg [nfa_pkg::NUM_SECTORS];
    logic [CW-1:0]               cnt_next [nfa_pkg::NUM_SECTORS];

    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  out_status_reg, out_status_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic [CW-1:0]               out_tot_reg, out_tot_next;
    logic [CW-1:0]               out_mx_reg, out_mx_next;
    logic                        out_last_reg, out_last_next;

    logic [7:0]                  flash_q;
    logic [7:0]                  page_q;
    logic                        fl_we;
    logic [7:0]                  fl_wdata;
    logic                        pg_we;
    logic                        out_free;
    logic                        load;
    logic                        mism;
    logic                        er_hit;
    logic [3:0]                  er_end;
    logic [nfa_pkg::BCNT_W-1:0]  n_beats;
    logic [2:0]                  rd_prot;
    logic [2:0]                  wr_prot;

    assign out_free = !out_valid_reg || rsp.ready;
    assign clearing = (state_reg == S_CLEAR);
    assign er_end   = {1'b0, q_item.er_first} + {1'b0, q_item.er_count};
    assign n_beats  = (bcount_reg < nfa_pkg::BCNT_W'(nfa_pkg::PAGE_BYTES)) ?
                      bcount_reg + 1'b1 : nfa_pkg::BCNT_W'(nfa_pkg::PAGE_BYTES + 1);
    assign rd_prot  = nfa_pkg::prot_bits(prot, q_item.addr[AW-1 -: nfa_pkg::SEC_W]);
    assign wr_prot  = nfa_pkg::prot_bits(prot, cur_reg.addr[AW-1 -: nfa_pkg::SEC_W]);

    always_comb
    begin
        er_hit = 1'b0;
        for (int s = 0; s < nfa_pkg::NUM_SECTORS; s++)
        begin
            if ((4'(s) >= {1'b0, q_item.er_first}) && (4'(s) < er_end) &&
                prot[3*s + nfa_pkg::PROT_ERASE])
            begin
                er_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            M_WRITE: mism = ((flash_q & page_q) != page_q);
            M_CMP:   mism = (flash_q != page_q);
            default: mism = (flash_q != nfa_pkg::ERASED);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cur_next        = cur_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        bidx_next       = bidx_reg;
        bcount_next     = bcount_reg;
        sidx_next       = sidx_reg;
        tot_next        = tot_reg;
        mx_next         = mx_reg;
        res_status_next = res_status_reg;
        res_stats_next  = res_stats_reg;
        cnt_next        = cnt_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_tot_next    = out_tot_reg;
        out_mx_next     = out_mx_reg;
        out_last_next   = out_last_reg;
        load            = 1'b0;
        pop             = 1'b0;
        fl_we           = 1'b0;
        fl_wdata        = nfa_pkg::ERASED;
        pg_we           = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                fl_we    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == LW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop             = 1'b1;
                    cur_next        = q_item;
                    res_stats_next  = 1'b0;
                    state_next      = S_EMIT;
                    res_status_next = nfa_pkg::ST_OK;
                    ptr_next        = q_item.addr;
                    rem_next        = q_item.len;
                    bidx_next       = '0;
                    case (q_item.kind)
                        nfa_pkg::K_READ:
                        begin
                            if (q_item.range_bad)
                                res_status_next = nfa_pkg::ST_ADDR;
                            else if (q_item.read_long)
                                res_status_next = nfa_pkg::ST_LEN;
                            else if (rd_prot[nfa_pkg::PROT_READ])
                                res_status_next = nfa_pkg::ST_PROT;
                            else
                                state_next = S_RD_ISSUE;
                        end
                        nfa_pkg::K_BEAT:
                        begin
                            if (bcount_reg < nfa_pkg::BCNT_W'(nfa_pkg::PAGE_BYTES))
                                pg_we = 1'b1;
                            bcount_next = n_beats;
                            mode_next   = q_item.is_cmp ? M_CMP : M_WRITE;
                            if (!q_item.data_last)
                                state_next = S_IDLE;
                            else
                            begin
                                bcount_next = '0;
                                if (q_item.range_bad)
                                    res_status_next = nfa_pkg::ST_ADDR;
                                else if (q_item.page_long ||
                                         (q_item.len != LW'(n_beats)))
                                    res_status_next = nfa_pkg::ST_LEN;
                                else
                                    state_next = S_CHK_ISS;
                            end
                        end
                        nfa_pkg::K_ERASE:
                        begin
                            ptr_next = {q_item.er_first[nfa_pkg::SEC_W-1:0],
                                        nfa_pkg::SOFF_W'(0)};
                            rem_next = LW'(q_item.er_count) << nfa_pkg::SOFF_W;
                            if (q_item.erase_bad)
                                res_status_next = nfa_pkg::ST_ADDR;
                            else if (er_hit)
                                res_status_next = nfa_pkg::ST_PROT;
                            else if (q_item.er_count != 3'd0)
                            begin
                                state_next = S_ERASE;
                                for (int s = 0; s < nfa_pkg::NUM_SECTORS; s++)
                                begin
                                    if ((4'(s) >= {1'b0, q_item.er_first}) &&
                                        (4'(s) < er_end))
                                        cnt_next[s] = cnt_reg[s] + 1'b1;
                                end
                            end
                        end
                        nfa_pkg::K_BLANK:
                        begin
                            mode_next = M_BLANK;
                            if (q_item.range_bad)
                                res_status_next = nfa_pkg::ST_ADDR;
                            else
                                state_next = S_CHK_ISS;
                        end
                        default:
                        begin
                            tot_next   = '0;
                            mx_next    = '0;
                            sidx_next  = '0;
                            state_next = S_STATS;
                        end
                    endcase
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = nfa_pkg::ST_OK;
                    out_byte_next   = flash_q;
                    out_tot_next    = '0;
                    out_mx_next     = '0;
                    out_last_next   = (rem_reg == LW'(1));
                    ptr_next        = ptr_reg + 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    state_next      = (rem_reg == LW'(1)) ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_CHK_ISS:
            begin
                state_next = S_CHK_EVAL;
            end
            S_CHK_EVAL:
            begin
                ptr_next   = ptr_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
                bidx_next  = bidx_reg + 1'b1;
                state_next = S_CHK_ISS;
                if (mism)
                begin
                    res_status_next = (mode_reg == M_WRITE) ? nfa_pkg::ST_WFAIL
                                                            : nfa_pkg::ST_CMP;
                    state_next      = S_EMIT;
                end
                else if (rem_reg == LW'(1))
                begin
                    res_status_next = nfa_pkg::ST_OK;
                    state_next      = S_EMIT;
                    if (mode_reg == M_WRITE)
                    begin
                        if (wr_prot[nfa_pkg::PROT_WRITE])
                            res_status_next = nfa_pkg::ST_PROT;
                        else
                        begin
                            ptr_next   = cur_reg.addr;
                            rem_next   = cur_reg.len;
                            bidx_next  = '0;
                            state_next = S_WR_ISS;
                        end
                    end
                end
            end
            S_WR_ISS:
            begin
                state_next = S_WR_EXEC;
            end
            S_WR_EXEC:
            begin
                fl_we      = 1'b1;
                fl_wdata   = flash_q & page_q;
                ptr_next   = ptr_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
                bidx_next  = bidx_reg + 1'b1;
                state_next = (rem_reg == LW'(1)) ? S_EMIT : S_WR_ISS;
            end
            S_ERASE:
            begin
                fl_we    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == LW'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_STATS:
            begin
                tot_next  = tot_reg + cnt_reg[sidx_reg];
                mx_next   = (cnt_reg[sidx_reg] > mx_reg) ? cnt_reg[sidx_reg] : mx_reg;
                sidx_next = sidx_reg + 1'b1;
                if (sidx_reg == nfa_pkg::SEC_W'(nfa_pkg::NUM_SECTORS - 1))
                begin
                    res_stats_next = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = res_status_reg;
                    out_byte_next   = '0;
                    out_tot_next    = res_stats_reg ? tot_reg : '0;
                    out_mx_next     = res_stats_reg ? mx_reg : '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            flash_mem[ptr_reg] <= fl_wdata;
        end
        flash_q <= flash_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[bcount_reg[nfa_pkg::PAGE_W-1:0]] <= q_item.data_byte;
        end
        page_q <= page_mem[bidx_reg];
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        mode_reg        <= mode_next;
        bidx_reg        <= bidx_next;
        sidx_reg        <= sidx_next;
        tot_reg         <= tot_next;
        mx_reg          <= mx_next;
        res_status_reg  <= res_status_next;
        res_stats_reg   <= res_stats_next;
        out_status_reg  <= out_status_next;
        out_byte_reg    <= out_byte_next;
        out_tot_reg     <= out_tot_next;
        out_mx_reg      <= out_mx_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            rem_reg       <= LW'(nfa_pkg::FLASH_BYTES);
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < nfa_pkg::NUM_SECTORS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.read_byte       = out_byte_reg;
    assign rsp.total_erases    = out_tot_reg;
    assign rsp.max_erase_count = out_mx_reg;
    assign rsp.last            = out_last_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("Result register overwritten while still held.");

    a_bcount_max: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= nfa_pkg::BCNT_W'(nfa_pkg::PAGE_BYTES + 1))
        else $error("Beat count out of range.");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop)
        else $error("Request taken during the clearing pass.");

    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ERASE) || (state_reg == S_CHK_EVAL) ||
         (state_reg == S_WR_EXEC)) |-> (rem_reg != '0))
        else $error("Loop running with nothing left to do.");

endmodule
